@@ rtl/fbpa_pkg.sv @@
// Shared types, constants and geometry helpers of the block pool allocator.
package fbpa_pkg;

    localparam int ADDR_W    = 32;
    localparam int SIZE_W    = 17;
    localparam int COUNT_W   = 11;
    localparam int STRIDE_W  = 18;
    localparam int CFG_IDX_W = 2;

    // Alignment of headers and block sizes; rounding below relies on a power of two
    localparam int ALIGN_BYTES = 4;
    localparam int HDR_BYTES   = ((12 + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    localparam int EEB_BYTES   = ((4 + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    localparam int USER_OFS    = HDR_BYTES + EEB_BYTES;

    localparam logic [SIZE_W-1:0]  SIZE_RST  = SIZE_W'(4);
    localparam logic [COUNT_W-1:0] COUNT_RST = COUNT_W'(1);

    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = CFG_IDX_W'(2);

    typedef enum logic [1:0] {
        REQ_INIT  = 2'd0,
        REQ_ALLOC = 2'd1,
        REQ_FREE  = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_FREE  = 2'd1,
        ST_BAD_ADDR = 2'd2
    } t_status;

    // Link word plus the block size rounded up to the alignment
    function automatic logic [STRIDE_W-1:0] stride_of(input logic [SIZE_W-1:0] size);
        logic [STRIDE_W-1:0] rounded;
        rounded = ({1'b0, size} + STRIDE_W'(ALIGN_BYTES - 1)) & ~STRIDE_W'(ALIGN_BYTES - 1);
        return rounded + STRIDE_W'(EEB_BYTES);
    endfunction

endpackage

@@ rtl/fixed_block_pool_allocator.sv @@
// Fixed-size block pool allocator with a LIFO free list held in a link memory.
//
// Usage: write base_address, block_size and block_count on the config port while
// the block is idle, then send an init request to chain all blocks in ascending
// order. Alloc pops the list head and returns its user address; free checks that
// the address is a block start inside the pool and pushes it, returning the
// header address. Every request gives exactly one result transfer.
// Input channel: i_valid / o_stall; a transfer happens when i_valid is high and
// o_stall is low. One request is in work at a time.
// Output channel: o_valid / i_stall; the result sits in an output register, so the
// next request is taken while a finished result still waits.
// Work per request: alloc does one link read; empty-list allocs, out-of-pool
// frees and reserved codes answer through the reply state; any free inside the pool,
// aligned or not, runs the stride divider, one quotient bit per cycle; init makes
// one link write per block, up to the saturated block_count.
// A stalled receiver holds the finishing request in its last state until the output
// register frees up. Reset empties the list and zeros the pool count; link memory
// contents are not cleared and are only read after init or free wrote them.
module fixed_block_pool_allocator #(
    parameter int MAX_BLOCKS = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fbpa_pkg::ADDR_W-1:0]       i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [1:0]                        i_req_type,
    input  logic [fbpa_pkg::ADDR_W-1:0]       i_free_address,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [fbpa_pkg::ADDR_W-1:0]       o_result_address,
    output logic [1:0]                        o_status
);

    import fbpa_pkg::*;

    localparam int IDX_W  = $clog2(MAX_BLOCKS + 1);
    localparam int MEM_AW = $clog2(MAX_BLOCKS);
    localparam int LIM_W  = (IDX_W + STRIDE_W > ADDR_W) ? IDX_W + STRIDE_W : ADDR_W;
    localparam int PROD_W = MEM_AW + STRIDE_W;
    localparam logic [IDX_W-1:0] NULL_IDX = IDX_W'(MAX_BLOCKS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_ALLOC,
        S_FREE,
        S_REPLY
    } t_state;

    t_state              r_state;

    // Configuration registers
    logic [ADDR_W-1:0]   r_base_address;
    logic [SIZE_W-1:0]   r_block_size;
    logic [COUNT_W-1:0]  r_block_count;

    // Pool geometry latched at init
    logic [STRIDE_W-1:0] r_pool_stride;
    logic [IDX_W-1:0]    r_pool_count;
    logic [LIM_W-1:0]    r_pool_limit;

    logic [IDX_W-1:0]    r_head;
    logic [IDX_W-1:0]    r_walk;
    logic [PROD_W-1:0]   r_prod;
    logic [ADDR_W-1:0]   r_free_address;
    logic [ADDR_W-1:0]   r_stage_addr;
    t_status             r_stage_sts;

    logic                r_out_valid;
    logic [ADDR_W-1:0]   r_result_address;
    t_status             r_status;

    logic [STRIDE_W-1:0] cfg_stride;
    logic                cfg_sat;
    logic [IDX_W-1:0]    cfg_count;
    logic [LIM_W-1:0]    n_pool_limit;
    logic [ADDR_W-1:0]   first_user;
    logic [ADDR_W-1:0]   free_off;
    logic                free_in_pool;
    logic                out_free;
    logic                out_load;
    logic                in_xfer;
    logic                walk_last;
    logic [IDX_W-1:0]    walk_next;

    logic                mem_we;
    logic [MEM_AW-1:0]   mem_waddr;
    logic [IDX_W-1:0]    mem_wdata;
    logic [MEM_AW-1:0]   mem_raddr;
    logic [IDX_W-1:0]    mem_rdata;

    logic                div_start;
    logic                div_busy;
    logic [MEM_AW-1:0]   div_quo;
    logic                div_rem_zero;

    // Geometry that an init request would latch, straight from the config registers
    assign cfg_stride   = stride_of(r_block_size);
    assign cfg_sat      = (ADDR_W'(r_block_count) > ADDR_W'(MAX_BLOCKS));
    assign cfg_count    = cfg_sat ? NULL_IDX : IDX_W'(r_block_count);
    assign n_pool_limit = LIM_W'(cfg_count) * LIM_W'(cfg_stride);

    // Free check: offset from the first user address must fall inside the pool
    assign first_user   = r_base_address + ADDR_W'(USER_OFS);
    assign free_off     = i_free_address - first_user;
    assign free_in_pool = (LIM_W'(free_off) < r_pool_limit);

    assign out_free  = !r_out_valid || !i_stall;
    assign in_xfer   = i_valid && (r_state == S_IDLE);
    assign o_stall   = (r_state != S_IDLE);

    // A request finishes and loads the output register in this cycle
    assign out_load  = out_free && ((r_state == S_ALLOC) || (r_state == S_REPLY) ||
                                    ((r_state == S_FREE) && !div_busy));

    assign walk_last = ((r_walk + IDX_W'(1)) == r_pool_count);
    assign walk_next = walk_last ? NULL_IDX : r_walk + IDX_W'(1);

    // Init walk and free push share the single write port; read always follows the head
    assign mem_we    = (r_state == S_INIT) ||
                       ((r_state == S_FREE) && !div_busy && out_free && div_rem_zero);
    assign mem_waddr = (r_state == S_INIT) ? r_walk[MEM_AW-1:0] : div_quo;
    assign mem_wdata = (r_state == S_INIT) ? walk_next : r_head;
    assign mem_raddr = (r_head == NULL_IDX) ? '0 : r_head[MEM_AW-1:0];

    assign div_start = in_xfer && (i_req_type == REQ_FREE) && free_in_pool;

    fbpa_link_mem #(
        .DEPTH (MAX_BLOCKS),
        .AW    (MEM_AW),
        .DW    (IDX_W)
    ) u_link_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    fbpa_div #(
        .DW (LIM_W),
        .VW (STRIDE_W),
        .QW (MEM_AW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (LIM_W'(free_off)),
        .i_divisor  (r_pool_stride),
        .o_busy     (div_busy),
        .o_quotient (div_quo),
        .o_rem_zero (div_rem_zero)
    );

    // Head block offset, registered so it is ready in the cycle after an alloc is taken
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(r_head[MEM_AW-1:0]) * PROD_W'(r_pool_stride);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_base_address <= '0;
            r_block_size   <= SIZE_RST;
            r_block_count  <= COUNT_RST;
            r_pool_stride  <= stride_of(SIZE_RST);
            r_pool_count   <= '0;
            r_pool_limit   <= '0;
            r_head         <= NULL_IDX;
            r_walk         <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BASE:  r_base_address <= i_cfg_data;
                    CFG_SIZE:  r_block_size   <= i_cfg_data[SIZE_W-1:0];
                    CFG_COUNT: r_block_count  <= i_cfg_data[COUNT_W-1:0];
                    default:   ;
                endcase
            end

            // Load a finished result, else drop the one just taken
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        case (i_req_type)
                            REQ_INIT: begin
                                r_pool_stride <= cfg_stride;
                                r_pool_count  <= cfg_count;
                                r_pool_limit  <= n_pool_limit;
                                r_walk        <= '0;
                                r_stage_addr  <= r_base_address;
                                r_stage_sts   <= ST_OK;
                                if (cfg_count == '0) begin
                                    r_head  <= NULL_IDX;
                                    r_state <= S_REPLY;
                                end else begin
                                    r_state <= S_INIT;
                                end
                            end
                            REQ_ALLOC: begin
                                if (r_head == NULL_IDX) begin
                                    r_stage_addr <= '0;
                                    r_stage_sts  <= ST_NO_FREE;
                                    r_state      <= S_REPLY;
                                end else begin
                                    r_state <= S_ALLOC;
                                end
                            end
                            REQ_FREE: begin
                                r_free_address <= i_free_address;
                                if (free_in_pool) begin
                                    r_state <= S_FREE;
                                end else begin
                                    r_stage_addr <= '0;
                                    r_stage_sts  <= ST_BAD_ADDR;
                                    r_state      <= S_REPLY;
                                end
                            end
                            default: begin
                                // Reserved request: answer and change nothing
                                r_stage_addr <= '0;
                                r_stage_sts  <= ST_OK;
                                r_state      <= S_REPLY;
                            end
                        endcase
                    end
                end

                S_INIT: begin
                    if (walk_last) begin
                        r_head  <= '0;
                        r_state <= S_REPLY;
                    end else begin
                        r_walk <= r_walk + IDX_W'(1);
                    end
                end

                S_ALLOC: begin
                    if (out_free) begin
                        r_head           <= mem_rdata;
                        r_result_address <= first_user + ADDR_W'(r_prod);
                        r_status         <= ST_OK;
                        r_state          <= S_IDLE;
                    end
                end

                S_FREE: begin
                    if (!div_busy && out_free) begin
                        if (div_rem_zero) begin
                            r_head           <= IDX_W'(div_quo);
                            r_result_address <= r_free_address - ADDR_W'(EEB_BYTES);
                            r_status         <= ST_OK;
                        end else begin
                            r_result_address <= '0;
                            r_status         <= ST_BAD_ADDR;
                        end
                        r_state <= S_IDLE;
                    end
                end

                S_REPLY: begin
                    if (out_free) begin
                        r_result_address <= r_stage_addr;
                        r_status         <= r_stage_sts;
                        r_state          <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid          = r_out_valid;
    assign o_result_address = r_result_address;
    assign o_status         = r_status;

    // The divider only runs on behalf of a free request
    a_div_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_busy |-> (r_state == S_FREE))
        else $error("divider busy outside free");

    // The init walk stays inside the latched pool
    a_walk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT) |-> (r_walk < r_pool_count))
        else $error("init walk beyond pool count");

    // Between requests the head is empty or names a block of the pool
    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ((r_head == NULL_IDX) || (r_head < r_pool_count)))
        else $error("free list head outside pool");

    // An alloc in work always has a block to pop
    a_alloc_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ALLOC) |-> (r_head != NULL_IDX))
        else $error("alloc popping empty list");

endmodule

@@ rtl/fbpa_link_mem.sv @@
// Next-free link memory: one write port, one read port, registered read data.
module fbpa_link_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 11
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/fbpa_div.sv @@
// Restoring divider, one quotient bit per cycle, for the free-address check.
module fbpa_div #(
    parameter int DW = 32,
    parameter int VW = 18,
    parameter int QW = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_busy,
    output logic [QW-1:0] o_quotient,
    output logic          o_rem_zero
);

    localparam int CW = $clog2(QW + 1);

    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_dsr;
    logic [QW-1:0] r_quo;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          fits;

    assign fits = (r_rem >= r_dsr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_rem  <= i_dividend;
            r_dsr  <= DW'(i_divisor) << (QW - 1);
            r_quo  <= '0;
            r_cnt  <= CW'(QW);
            r_busy <= 1'b1;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= r_rem - r_dsr;
            end
            r_quo  <= (r_quo << 1) | QW'(fits);
            r_dsr  <= r_dsr >> 1;
            r_cnt  <= r_cnt - CW'(1);
            r_busy <= (r_cnt != CW'(1));
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;
    assign o_rem_zero = (r_rem == '0);

endmodule
